// ===== rtl/averaged_power_spectrum_core_assert.svh =====
// Assertion helpers for the RTL of the averaged power spectrum core.
`ifndef AVERAGED_POWER_SPECTRUM_CORE_ASSERT_SVH
`define AVERAGED_POWER_SPECTRUM_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define APS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define APS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/aps_pkg.sv =====
package aps_pkg;

    localparam int BINS_DEF        = 64;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF  = 24;

    localparam int STEP_W      = 11;
    localparam int DT_W        = 32;
    localparam int DT_FRAC     = 16;
    localparam int POWER_W     = 48;
    localparam int INDEX_W     = 6;
    localparam int SEG_W       = 16;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 32;
    localparam int TW_FRAC     = 15;
    localparam int CIRCLE_BITS = 7;
    localparam int COS_W       = 17;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELTA_T   = 8'd1;

    localparam logic [POWER_W-1:0] POWER_MAX = {POWER_W{1'b1}};
    localparam logic [SEG_W-1:0]   SEG_MAX   = {SEG_W{1'b1}};

    // Quarter wave of cos(2*pi*j/128) in Q15
    localparam logic [COS_W-1:0] QCOS [0:32] = '{
        17'd32768, 17'd32729, 17'd32610, 17'd32413, 17'd32138, 17'd31786, 17'd31357,
        17'd30853, 17'd30274, 17'd29622, 17'd28899, 17'd28106, 17'd27246, 17'd26320,
        17'd25330, 17'd24279, 17'd23170, 17'd22006, 17'd20788, 17'd19520, 17'd18205,
        17'd16846, 17'd15447, 17'd14010, 17'd12540, 17'd11039, 17'd9512,  17'd7962,
        17'd6393,  17'd4808,  17'd3212,  17'd1608,  17'd0
    };

    typedef struct packed {
        logic wr_en;
        logic start;
        logic clear;
    } aps_dft_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } aps_dft_stat_t;

    function automatic logic signed [COS_W-1:0] cos_at(input logic [CIRCLE_BITS-1:0] j);
        logic [7:0]         jj;
        logic [7:0]         idx;
        logic               neg;
        logic signed [17:0] mag;
        jj = {1'b0, j};
        if (jj <= 8'd32)
        begin
            idx = jj;
            neg = 1'b0;
        end
        else if (jj <= 8'd64)
        begin
            idx = 8'd64 - jj;
            neg = 1'b1;
        end
        else if (jj <= 8'd96)
        begin
            idx = jj - 8'd64;
            neg = 1'b1;
        end
        else
        begin
            idx = 8'd128 - jj;
            neg = 1'b0;
        end
        mag = $signed({1'b0, QCOS[idx[5:0]]});
        return neg ? COS_W'(-mag) : COS_W'(mag);
    endfunction

    function automatic logic signed [COS_W-1:0] sin_at(input logic [CIRCLE_BITS-1:0] j);
        return cos_at(j + 7'd96);
    endfunction

endpackage

// ===== rtl/aps_sample_if.sv =====
interface aps_sample_if import aps_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;

    modport source (output valid, sample, last, input ready);
    modport sink (input valid, sample, last, output ready);
endinterface

// ===== rtl/aps_result_if.sv =====
interface aps_result_if import aps_pkg::*;;
    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] bin_index;
    logic [POWER_W-1:0] bin_power;
    logic               too_short;
    logic               final_bin;

    modport source (output valid, bin_index, bin_power, too_short, final_bin, input ready);
    modport sink (input valid, bin_index, bin_power, too_short, final_bin, output ready);
endinterface

// ===== rtl/aps_cfg_if.sv =====
interface aps_cfg_if import aps_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/aps_dft.sv =====
module aps_dft import aps_pkg::*; #(
    parameter int BINS        = BINS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  aps_dft_cmd_t                    cmd,
    input  logic [$clog2(BINS)-1:0]         wr_addr,
    input  logic signed [SAMPLE_BITS-1:0]   wr_data,
    input  logic [$clog2(BINS)-1:0]         base,
    input  logic [$clog2(BINS)-2:0]         rd_addr,
    output logic [POWER_W-1:0]              rd_data,
    output aps_dft_stat_t                   stat
);
    localparam int LOG_BINS = $clog2(BINS);
    localparam int HALF     = BINS / 2;
    localparam int HALF_W   = LOG_BINS - 1;
    localparam int PROD_W   = SAMPLE_BITS + COS_W;
    localparam int ACC_W    = SAMPLE_BITS + TW_FRAC + LOG_BINS + 2;
    localparam int MAG_W    = SAMPLE_BITS + LOG_BINS;
    localparam int PW_W     = 2 * MAG_W + 1;
    localparam int SUM_W    = ((PW_W > POWER_W) ? PW_W : POWER_W) + 1;

    localparam logic [2:0] D_IDLE  = 3'd0;
    localparam logic [2:0] D_RD    = 3'd1;
    localparam logic [2:0] D_MUL   = 3'd2;
    localparam logic [2:0] D_ACC   = 3'd3;
    localparam logic [2:0] D_RND   = 3'd4;
    localparam logic [2:0] D_SQR_R = 3'd5;
    localparam logic [2:0] D_SQR_I = 3'd6;
    localparam logic [2:0] D_UPD   = 3'd7;

    logic [2:0]                    state_reg, state_next;
    logic [LOG_BINS-1:0]           base_reg, base_next;
    logic [LOG_BINS-1:0]           k_reg, k_next;
    logic [LOG_BINS-1:0]           n_reg, n_next;
    logic [LOG_BINS-1:0]           tw_reg, tw_next;
    logic signed [COS_W-1:0]       cos_reg, cos_next;
    logic signed [COS_W-1:0]       sin_reg, sin_next;
    logic signed [PROD_W-1:0]      pre_reg, pre_next;
    logic signed [PROD_W-1:0]      pim_reg, pim_next;
    logic signed [ACC_W-1:0]       re_reg, re_next;
    logic signed [ACC_W-1:0]       im_reg, im_next;
    logic [MAG_W-1:0]              r_reg, r_next;
    logic [MAG_W-1:0]              i_reg, i_next;
    logic [PW_W-1:0]               sq_reg, sq_next;
    logic [PW_W-1:0]               pw_reg, pw_next;

    logic signed [SAMPLE_BITS-1:0] ring [BINS];
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic [POWER_W-1:0]            accum_reg [HALF];
    logic [HALF-1:0]               valid_reg;

    logic [LOG_BINS-1:0]           rd_ptr;
    logic [CIRCLE_BITS-1:0]        tw_angle;
    logic [HALF_W-1:0]             k_idx;
    logic [HALF_W-1:0]             acc_addr;
    logic [POWER_W-1:0]            acc_cur;
    logic [ACC_W-1:0]              abs_re, abs_im;
    logic [SUM_W-1:0]              sum;
    logic [POWER_W-1:0]            sat;
    logic                          upd_we;
    logic                          done;

    assign rd_ptr   = LOG_BINS'(base_reg + n_reg);
    assign tw_angle = CIRCLE_BITS'(CIRCLE_BITS'(tw_reg) << (CIRCLE_BITS - LOG_BINS));
    assign k_idx    = HALF_W'(k_reg - LOG_BINS'(1));
    assign acc_addr = (state_reg == D_UPD) ? k_idx : rd_addr;
    assign acc_cur  = valid_reg[acc_addr] ? accum_reg[acc_addr] : '0;
    assign rd_data  = acc_cur;
    assign abs_re   = re_reg[ACC_W-1] ? ACC_W'(-re_reg) : ACC_W'(re_reg);
    assign abs_im   = im_reg[ACC_W-1] ? ACC_W'(-im_reg) : ACC_W'(im_reg);
    assign sum      = SUM_W'(acc_cur) + SUM_W'(pw_reg);
    assign sat      = (sum > SUM_W'(POWER_MAX)) ? POWER_MAX : sum[POWER_W-1:0];
    assign upd_we   = (state_reg == D_UPD);

    assign stat.busy = (state_reg != D_IDLE);
    assign stat.done = done;

    always_comb
    begin
        state_next = state_reg;
        base_next  = base_reg;
        k_next     = k_reg;
        n_next     = n_reg;
        tw_next    = tw_reg;
        cos_next   = cos_reg;
        sin_next   = sin_reg;
        pre_next   = pre_reg;
        pim_next   = pim_reg;
        re_next    = re_reg;
        im_next    = im_reg;
        r_next     = r_reg;
        i_next     = i_reg;
        sq_next    = sq_reg;
        pw_next    = pw_reg;
        done       = 1'b0;
        case (state_reg)
            D_IDLE:
            begin
                if (cmd.start)
                begin
                    base_next  = base;
                    k_next     = LOG_BINS'(1);
                    n_next     = '0;
                    tw_next    = '0;
                    re_next    = '0;
                    im_next    = '0;
                    state_next = D_RD;
                end
            end
            D_RD:
            begin
                cos_next   = cos_at(tw_angle);
                sin_next   = sin_at(tw_angle);
                state_next = D_MUL;
            end
            D_MUL:
            begin
                pre_next   = x_reg * cos_reg;
                pim_next   = x_reg * sin_reg;
                state_next = D_ACC;
            end
            D_ACC:
            begin
                re_next = re_reg + ACC_W'(pre_reg);
                im_next = im_reg + ACC_W'(pim_reg);
                n_next  = n_reg + LOG_BINS'(1);
                tw_next = tw_reg + k_reg;
                state_next = (n_reg == {LOG_BINS{1'b1}}) ? D_RND : D_RD;
            end
            D_RND:
            begin
                r_next = MAG_W'((abs_re + ACC_W'(1 << (TW_FRAC - 1))) >> TW_FRAC);
                i_next = MAG_W'((abs_im + ACC_W'(1 << (TW_FRAC - 1))) >> TW_FRAC);
                state_next = D_SQR_R;
            end
            D_SQR_R:
            begin
                sq_next    = PW_W'(r_reg) * PW_W'(r_reg);
                state_next = D_SQR_I;
            end
            D_SQR_I:
            begin
                pw_next    = sq_reg + PW_W'(i_reg) * PW_W'(i_reg);
                state_next = D_UPD;
            end
            D_UPD:
            begin
                if (k_reg == LOG_BINS'(HALF))
                begin
                    done       = 1'b1;
                    state_next = D_IDLE;
                end
                else
                begin
                    k_next     = k_reg + LOG_BINS'(1);
                    n_next     = '0;
                    tw_next    = '0;
                    re_next    = '0;
                    im_next    = '0;
                    state_next = D_RD;
                end
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.clear)
            begin
                valid_reg <= '0;
            end
            else if (upd_we)
            begin
                valid_reg[k_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        k_reg    <= k_next;
        n_reg    <= n_next;
        tw_reg   <= tw_next;
        cos_reg  <= cos_next;
        sin_reg  <= sin_next;
        pre_reg  <= pre_next;
        pim_reg  <= pim_next;
        re_reg   <= re_next;
        im_reg   <= im_next;
        r_reg    <= r_next;
        i_reg    <= i_next;
        sq_reg   <= sq_next;
        pw_reg   <= pw_next;
        if (upd_we)
        begin
            accum_reg[k_idx] <= sat;
        end
    end

    // Sample ring: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            ring[wr_addr] <= wr_data;
        end
        x_reg <= ring[rd_ptr];
    end

endmodule

// ===== rtl/aps_scale.sv =====
module aps_scale import aps_pkg::*; #(
    parameter int BINS = BINS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [POWER_W-1:0] acc,
    input  logic [DT_W-1:0]    dt,
    input  logic [SEG_W-1:0]   segs,
    output logic               done,
    output logic [POWER_W-1:0] q
);
    localparam int LOG_BINS = $clog2(BINS);
    // power * dt * 2 / (segs * BINS * 2^16) = (power * dt >> SHIFT) / segs
    localparam int SHIFT  = LOG_BINS + DT_FRAC - 1;
    localparam int PROD_W = POWER_W + DT_W;
    localparam int NUM_W  = PROD_W - SHIFT;
    localparam int CNT_W  = $clog2(NUM_W + 1);

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_MLO  = 2'd1;
    localparam logic [1:0] C_MHI  = 2'd2;
    localparam logic [1:0] C_DIV  = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic                   done_reg, done_next;
    logic [POWER_W-1:0]     acc_reg, acc_next;
    logic [DT_W-1:0]        dt_reg, dt_next;
    logic [SEG_W-1:0]       segs_reg, segs_next;
    logic [2*DT_W-1:0]      plo_reg, plo_next;
    logic [NUM_W-1:0]       work_reg, work_next;
    logic [SEG_W-1:0]       rem_reg, rem_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;

    logic [DT_W-1:0]        mul_a;
    logic [2*DT_W-1:0]      mul_p;
    logic [PROD_W-1:0]      prod;
    logic [SEG_W:0]         trial;
    logic                   fits;

    // One 32x32 multiplier serves both halves of the power word
    assign mul_a = (state_reg == C_MLO) ? acc_reg[DT_W-1:0]
                                        : DT_W'(acc_reg[POWER_W-1:DT_W]);
    assign mul_p = (2*DT_W)'(mul_a) * (2*DT_W)'(dt_reg);
    assign prod  = PROD_W'({mul_p, {DT_W{1'b0}}}) + PROD_W'(plo_reg);
    assign trial = {rem_reg, work_reg[NUM_W-1]};
    assign fits  = (trial >= {1'b0, segs_reg});

    assign done = done_reg;
    assign q    = (|work_reg[NUM_W-1:POWER_W]) ? POWER_MAX : work_reg[POWER_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        acc_next   = acc_reg;
        dt_next    = dt_reg;
        segs_next  = segs_reg;
        plo_next   = plo_reg;
        work_next  = work_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    acc_next   = acc;
                    dt_next    = dt;
                    segs_next  = segs;
                    state_next = C_MLO;
                end
            end
            C_MLO:
            begin
                plo_next   = mul_p;
                state_next = C_MHI;
            end
            C_MHI:
            begin
                work_next  = NUM_W'(prod >> SHIFT);
                rem_next   = '0;
                cnt_next   = '0;
                state_next = C_DIV;
            end
            C_DIV:
            begin
                // Restoring division, one quotient bit a cycle
                rem_next  = fits ? SEG_W'(trial - {1'b0, segs_reg}) : trial[SEG_W-1:0];
                work_next = {work_reg[NUM_W-2:0], fits};
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    done_next  = 1'b1;
                    state_next = C_IDLE;
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        dt_reg   <= dt_next;
        segs_reg <= segs_next;
        plo_reg  <= plo_next;
        work_reg <= work_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
    end

endmodule

// ===== rtl/averaged_power_spectrum_core.sv =====
// Averaged power spectrum of a sample record (rectangular window, overlapping segments).
// samples: one signed sample per word, last marks the end of the record.
// results: on the last sample, BINS/2 words (bins 1..BINS/2 as index 0..BINS/2-1)
//   with the scaled averaged power, final_bin on the last one; a record with no
//   full segment gives a single word with too_short and final_bin set.
// cfg: write index 0 = step_size (0 acts as 1), index 1 = delta_t (Q16.16).
//   Always ready; write only while the block is idle.
// Flow: a sample that closes neither a segment nor the record leaves ready high. A sample that closes
//   a segment holds ready low while the complex MAC runs the DFT: each tap
//   steps through read, multiply and accumulate, BINS taps per bin, and each bin
//   then rounds, squares and updates its sum. Each output word then goes through
//   the shared multiply/divide unit before it is offered to the receiver.
// Ready stays low while a result word waits; a stalled receiver just holds the
//   word in the output register. Reset clears counters and bin sums and
//   restores step_size 32 and delta_t 1.0; the sample ring is not cleared.
`include "averaged_power_spectrum_core_assert.svh"

module averaged_power_spectrum_core import aps_pkg::*; #(
    parameter int BINS        = BINS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    aps_sample_if.sink    samples,
    aps_result_if.source  results,
    aps_cfg_if.sink       cfg
);
    localparam int LOG_BINS = $clog2(BINS);
    localparam int HALF_W   = LOG_BINS - 1;
    localparam int HALF     = BINS / 2;
    localparam int END_W    = ((COUNT_BITS > STEP_W) ? COUNT_BITS : STEP_W) + 1;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [2:0] T_IDLE  = 3'd0;
    localparam logic [2:0] T_SEG   = 3'd1;
    localparam logic [2:0] T_SGO   = 3'd2;
    localparam logic [2:0] T_SWAIT = 3'd3;
    localparam logic [2:0] T_OUT   = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [STEP_W-1:0]     step_reg;
    logic [DT_W-1:0]       dt_reg;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [COUNT_BITS-1:0] seg_end_reg, seg_end_next;
    logic [SEG_W-1:0]      segs_reg, segs_next;
    logic                  last_reg, last_next;
    logic [HALF_W-1:0]     bin_reg, bin_next;
    logic                  ovalid_reg, ovalid_next;
    logic [INDEX_W-1:0]    oindex_reg, oindex_next;
    logic [POWER_W-1:0]    opower_reg, opower_next;
    logic                  oshort_reg, oshort_next;
    logic                  ofinal_reg, ofinal_next;

    logic                  accept;
    logic                  seg_hit;
    logic [STEP_W-1:0]     step_eff;
    logic [END_W-1:0]      end_sum;
    logic [COUNT_BITS-1:0] end_sat;
    logic                  clear_rec;
    logic                  scale_start;
    logic                  scale_done;
    logic [POWER_W-1:0]    scale_q;
    logic [POWER_W-1:0]    acc_rd;
    aps_dft_cmd_t          dcmd;
    aps_dft_stat_t         dstat;

    assign samples.ready     = (state_reg == T_IDLE);
    assign accept            = samples.valid && samples.ready;
    assign results.valid     = ovalid_reg;
    assign results.bin_index = oindex_reg;
    assign results.bin_power = opower_reg;
    assign results.too_short = oshort_reg;
    assign results.final_bin = ofinal_reg;
    assign cfg.ready         = 1'b1;

    assign seg_hit  = (count_reg != COUNT_MAX) && (count_reg == seg_end_reg) &&
                      (segs_reg != SEG_MAX);
    assign step_eff = (step_reg == '0) ? STEP_W'(1) : step_reg;
    assign end_sum  = END_W'(seg_end_reg) + END_W'(step_eff);
    assign end_sat  = (end_sum > END_W'(COUNT_MAX)) ? COUNT_MAX : end_sum[COUNT_BITS-1:0];

    assign dcmd.wr_en = accept;
    assign dcmd.start = accept && seg_hit;
    assign dcmd.clear = clear_rec;

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        seg_end_next = seg_end_reg;
        segs_next    = segs_reg;
        last_next    = last_reg;
        bin_next     = bin_reg;
        ovalid_next  = ovalid_reg;
        oindex_next  = oindex_reg;
        opower_next  = opower_reg;
        oshort_next  = oshort_reg;
        ofinal_next  = ofinal_reg;
        clear_rec    = 1'b0;
        scale_start  = 1'b0;
        case (state_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    if (count_reg != COUNT_MAX)
                    begin
                        count_next = count_reg + COUNT_BITS'(1);
                    end
                    last_next = samples.last;
                    if (seg_hit)
                    begin
                        segs_next    = segs_reg + SEG_W'(1);
                        seg_end_next = end_sat;
                        state_next   = T_SEG;
                    end
                    else if (samples.last)
                    begin
                        if (segs_reg == '0)
                        begin
                            ovalid_next = 1'b1;
                            oindex_next = '0;
                            opower_next = '0;
                            oshort_next = 1'b1;
                            ofinal_next = 1'b1;
                            state_next  = T_OUT;
                        end
                        else
                        begin
                            bin_next   = '0;
                            state_next = T_SGO;
                        end
                    end
                end
            end
            T_SEG:
            begin
                // A segment just ran, so at least one segment exists here
                if (dstat.done)
                begin
                    bin_next   = '0;
                    state_next = last_reg ? T_SGO : T_IDLE;
                end
            end
            T_SGO:
            begin
                scale_start = 1'b1;
                state_next  = T_SWAIT;
            end
            T_SWAIT:
            begin
                if (scale_done)
                begin
                    ovalid_next = 1'b1;
                    oindex_next = INDEX_W'(bin_reg);
                    opower_next = scale_q;
                    oshort_next = 1'b0;
                    ofinal_next = (bin_reg == HALF_W'(HALF - 1));
                    state_next  = T_OUT;
                end
            end
            T_OUT:
            begin
                if (results.ready)
                begin
                    ovalid_next = 1'b0;
                    if (ofinal_reg)
                    begin
                        clear_rec    = 1'b1;
                        count_next   = '0;
                        segs_next    = '0;
                        seg_end_next = COUNT_BITS'(BINS - 1);
                        state_next   = T_IDLE;
                    end
                    else
                    begin
                        bin_next   = bin_reg + HALF_W'(1);
                        state_next = T_SGO;
                    end
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= T_IDLE;
            step_reg    <= STEP_W'(32);
            dt_reg      <= DT_W'(65536);
            count_reg   <= '0;
            seg_end_reg <= COUNT_BITS'(BINS - 1);
            segs_reg    <= '0;
            last_reg    <= 1'b0;
            bin_reg     <= '0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            seg_end_reg <= seg_end_next;
            segs_reg    <= segs_next;
            last_reg    <= last_next;
            bin_reg     <= bin_next;
            ovalid_reg  <= ovalid_next;
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == REG_STEP_SIZE)
                begin
                    step_reg <= cfg.data[STEP_W-1:0];
                end
                else if (cfg.index == REG_DELTA_T)
                begin
                    dt_reg <= cfg.data[DT_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        oindex_reg <= oindex_next;
        opower_reg <= opower_next;
        oshort_reg <= oshort_next;
        ofinal_reg <= ofinal_next;
    end

    aps_dft #(
        .BINS        (BINS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dft (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (dcmd),
        .wr_addr (count_reg[LOG_BINS-1:0]),
        .wr_data (samples.sample),
        .base    (LOG_BINS'(count_reg[LOG_BINS-1:0] + LOG_BINS'(1))),
        .rd_addr (bin_reg),
        .rd_data (acc_rd),
        .stat    (dstat)
    );

    aps_scale #(
        .BINS (BINS)
    ) u_scale (
        .clk   (clk),
        .rst_n (rst_n),
        .start (scale_start),
        .acc   (acc_rd),
        .dt    (dt_reg),
        .segs  (segs_reg),
        .done  (scale_done),
        .q     (scale_q)
    );

    `APS_ASSERT_IMP(a_no_accept_with_result, clk, rst_n, samples.valid && samples.ready, !results.valid, "sample accepted while a result word is pending")
    `APS_ASSERT_IMP(a_dft_done_in_seg, clk, rst_n, dstat.done, state_reg == T_SEG, "segment finished outside the segment wait state")
    `APS_ASSERT_NXT(a_final_clears_record, clk, rst_n, results.valid && results.ready && results.final_bin, state_reg == T_IDLE && count_reg == '0 && segs_reg == '0, "record state not cleared after final word")

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import aps_pkg::*;

    typedef struct {
        logic [INDEX_W-1:0] idx;
        logic [POWER_W-1:0] pw;
        logic               ts;
        logic               fb;
    } bin_word_t;

    // Tracks the spectrum state and holds the bin words still owed by the block.
    class spectrum_scoreboard;
        int unsigned     step;
        longint unsigned dt;
        longint          ring [64];
        longint unsigned acc [32];
        longint unsigned cnt;
        longint unsigned segs;
        longint unsigned next_end;
        bin_word_t       owed [$];
        int              errors;
        int              words_seen;
        int              records;
        int              segs_total;

        static int qtab [33] = '{
            32768, 32729, 32610, 32413, 32138, 31786, 31357, 30853,
            30274, 29622, 28899, 28106, 27246, 26320, 25330, 24279,
            23170, 22006, 20788, 19520, 18205, 16846, 15447, 14010,
            12540, 11039, 9512, 7962, 6393, 4808, 3212, 1608, 0
        };

        function new();
            step = 32;
            dt = 65536;
            foreach (ring[i]) ring[i] = 0;
            errors = 0;
            words_seen = 0;
            records = 0;
            segs_total = 0;
            clear_record();
        endfunction

        function void clear_record();
            foreach (acc[i]) acc[i] = 0;
            cnt = 0;
            segs = 0;
            next_end = 63;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_STEP_SIZE)
                step = val[STEP_W-1:0];
            else if (idx == REG_DELTA_T)
                dt = val;
        endfunction

        function longint twiddle(int j);
            j = j & 127;
            if (j <= 32) return qtab[j];
            if (j <= 64) return -qtab[64 - j];
            if (j <= 96) return -qtab[j - 64];
            return qtab[128 - j];
        endfunction

        function longint unsigned round_abs(longint s);
            longint unsigned m;
            m = (s < 0) ? longint'(-s) : s;
            return (m + 16384) >> 15;
        endfunction

        function void add_segment(longint unsigned seg_end);
            longint          re, im, x;
            longint unsigned r, q, pw;
            int              j;
            for (int k = 1; k <= 32; k++)
            begin
                re = 0;
                im = 0;
                for (int n = 0; n < 64; n++)
                begin
                    x = ring[(seg_end + 1 + n) & 63];
                    j = ((k * n) % 64) * 2;
                    re += x * twiddle(j);
                    im += x * twiddle(j + 96);
                end
                r = round_abs(re);
                q = round_abs(im);
                pw = r * r + q * q;
                if (pw > POWER_MAX - acc[k-1])
                    acc[k-1] = POWER_MAX;
                else
                    acc[k-1] += pw;
            end
        endfunction

        function logic [POWER_W-1:0] scaled(longint unsigned a);
            logic [127:0] num, den, q;
            num = 128'(a) * 128'(dt) * 128'd2;
            den = 128'(segs) * 128'd64 * 128'd65536;
            q = num / den;
            if (q > 128'(POWER_MAX))
                return POWER_MAX;
            return q[POWER_W-1:0];
        endfunction

        function void note_sample(logic signed [15:0] smp, logic lst);
            bin_word_t       w;
            longint unsigned cmax;
            cmax = (64'd1 << 24) - 1;
            ring[cnt & 63] = smp;
            if (cnt < cmax && cnt == next_end && segs < 65535)
            begin
                add_segment(cnt);
                segs++;
                segs_total++;
                next_end += (step == 0) ? 1 : step;
                if (next_end > cmax)
                    next_end = cmax;
            end
            if (cnt < cmax)
                cnt++;
            if (!lst)
                return;
            records++;
            if (segs == 0)
            begin
                w.idx = '0;
                w.pw = '0;
                w.ts = 1'b1;
                w.fb = 1'b1;
                owed.push_back(w);
            end
            else
            begin
                for (int k = 0; k < 32; k++)
                begin
                    w.idx = INDEX_W'(k);
                    w.pw = scaled(acc[k]);
                    w.ts = 1'b0;
                    w.fb = (k == 31);
                    owed.push_back(w);
                end
            end
            clear_record();
        endfunction

        function void check_word(bin_word_t got);
            bin_word_t want;
            words_seen++;
            if (owed.size() == 0)
            begin
                $display("%0t: unexpected word idx=%0d power=%0d", $time, got.idx, got.pw);
                errors++;
                return;
            end
            want = owed.pop_front();
            if (got.idx !== want.idx)
            begin
                $display("%0t: bin_index expected %0d actual %0d", $time, want.idx, got.idx);
                errors++;
            end
            if (got.pw !== want.pw)
            begin
                $display("%0t: bin_power (idx %0d) expected %0d actual %0d",
                         $time, want.idx, want.pw, got.pw);
                errors++;
            end
            if (got.ts !== want.ts)
            begin
                $display("%0t: too_short expected %0b actual %0b", $time, want.ts, got.ts);
                errors++;
            end
            if (got.fb !== want.fb)
            begin
                $display("%0t: final_bin expected %0b actual %0b", $time, want.fb, got.fb);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    aps_sample_if #(.SAMPLE_BITS(16)) sif ();
    aps_result_if rif ();
    aps_cfg_if    cif ();

    averaged_power_spectrum_core u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sif),
        .results (rif),
        .cfg     (cif)
    );

    spectrum_scoreboard sb;
    int  idle_cycles;
    bit  moved;
    bit  hold_req;
    int  burst_left;
    int  items_sent;
    bit  no_gaps;

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        sif.valid = 1'b0;
        sif.sample = '0;
        sif.last = 1'b0;
        rif.ready = 1'b0;
        cif.valid = 1'b0;
        cif.index = '0;
        cif.data = '0;
        hold_req = 1'b0;
        sb = new();
    end

    always #5 clk = ~clk;

    // Monitors sample on the falling edge, where all handshake signals are settled.
    always @(negedge clk)
    begin
        bin_word_t w;
        moved = 1'b0;
        if (rst_n && sif.valid && sif.ready)
        begin
            sb.note_sample(sif.sample, sif.last);
            moved = 1'b1;
        end
        if (rst_n && rif.valid && rif.ready)
        begin
            w.idx = rif.bin_index;
            w.pw = rif.bin_power;
            w.ts = rif.too_short;
            w.fb = rif.final_bin;
            sb.check_word(w);
            moved = 1'b1;
        end
        if (rst_n && cif.valid && cif.ready)
        begin
            sb.write_reg(cif.index, cif.data);
            moved = 1'b1;
        end
    end

    // Neither a segment DFT nor the long receiver hold moves any word.
    always @(posedge clk)
    begin
        if (!rst_n || moved)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 200000)
        begin
            $display("%0t: watchdog expired, %0d words still owed", $time, sb.owed.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver: alternate free-flowing and choppy stretches, plus one long hold.
    initial
    begin
        int hold_cnt;
        int mode_left;
        bit choppy;
        hold_cnt = 0;
        mode_left = 0;
        choppy = 1'b0;
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                choppy = 1'($urandom_range(0, 1));
                mode_left = $urandom_range(50, 400);
            end
            mode_left--;
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_cnt = 30000;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                rif.ready <= 1'b0;
            end
            else if (choppy)
                rif.ready <= ($urandom_range(0, 2) != 0);
            else
                rif.ready <= 1'b1;
        end
    end

    task automatic send_sample(input logic signed [15:0] smp, input logic lst);
        int gap;
        if (burst_left == 0 && !no_gaps)
        begin
            gap = $urandom_range(1, 8);
            sif.valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0)
            burst_left--;
        sif.valid <= 1'b1;
        sif.sample <= smp;
        sif.last <= lst;
        @(negedge clk);
        while (!sif.ready)
            @(negedge clk);
        @(posedge clk);
        items_sent++;
    endtask

    task automatic send_record(input int len, input bit extremes);
        logic signed [15:0] smp;
        for (int i = 0; i < len; i++)
        begin
            if (extremes)
                smp = (i % 2) ? 16'sh7FFF : 16'sh8000;
            else if ($urandom_range(0, 9) == 0)
                smp = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            else
                smp = 16'($urandom);
            send_sample(smp, i == len - 1);
        end
    endtask

    // Drain every owed word, then let the block settle before touching registers.
    task automatic drain();
        sif.valid <= 1'b0;
        @(posedge clk);
        while (sb.owed.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cif.valid <= 1'b1;
        cif.index <= idx;
        cif.data <= val;
        @(negedge clk);
        while (!cif.ready)
            @(negedge clk);
        @(posedge clk);
        cif.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_phase(input logic [CFG_DATA_W-1:0] step, input logic [CFG_DATA_W-1:0] dt);
        drain();
        write_cfg(REG_STEP_SIZE, step);
        write_cfg(REG_DELTA_T, dt);
        @(posedge clk);
    endtask

    initial
    begin
        int len;
        int phase;
        logic [CFG_DATA_W-1:0] dt;
        burst_left = 0;
        items_sent = 0;
        no_gaps = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // Reset settings: short records and one exact segment of extremes.
        send_sample(16'sh8000, 1'b1);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'shFFFF, 1'b1);
        send_sample(16'sh0000, 1'b1);
        send_record(64, 1'b1);

        set_phase(1, 1);
        send_record(66, 1'b0);
        set_phase(0, 32'hFFFF_FFFF);
        send_record(65, 1'b1);
        set_phase(1024, 65536);
        write_cfg(8'd7, 32'hDEAD_BEEF);
        send_record(100, 1'b0);
        set_phase(2047, 32'h0000_8000);
        send_record(70, 1'b0);

        phase = 0;
        while (items_sent < 440)
        begin
            dt = $urandom_range(0, 2) == 0 ? $urandom : $urandom_range(1, 32'h0004_0000);
            if (dt == 0)
                dt = 1;
            set_phase($urandom_range(16, 64), dt);
            no_gaps = (phase % 3 == 2);
            for (int r = 0; r < 3; r++)
            begin
                if (items_sent >= 440)
                    break;
                if (phase == 0 && r == 0)
                    hold_req = 1'b1;
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 63)
                                                  : $urandom_range(64, 150);
                send_record(len, 1'b0);
            end
            phase++;
        end

        drain();
        repeat (200) @(posedge clk);
        $display("Covered %0d records, %0d segments, %0d samples, %0d result words.",
                 sb.records, sb.segs_total, items_sent, sb.words_seen);
        if (sb.errors == 0 && sb.owed.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/aps_pkg.sv
rtl/aps_sample_if.sv
rtl/aps_result_if.sv
rtl/aps_cfg_if.sv
rtl/aps_dft.sv
rtl/aps_scale.sv
rtl/averaged_power_spectrum_core.sv
bench/tb.sv
